// File: design/sbopd_pkg.sv
// shared types, codes and constants of the sphere and box overlap pair detector
package sbopd_pkg;

  localparam int DEF_TABLE_DEPTH = 32;

  localparam int ACTION_W    = 2;
  localparam int ID_W        = 16;
  localparam int POS_W       = 24;
  localparam int EXT_W       = 23;
  localparam int STATUS_W    = 2;
  localparam int HIT_INDEX_W = 5;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 1;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_DUP  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_SHAPE_KIND  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MODE_MUTUAL = 2'd1;

  typedef struct packed {
    logic [ACTION_W-1:0]    action;
    logic [ID_W-1:0]        entry_id;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [EXT_W-1:0]       radius;
    logic [EXT_W-1:0]       size_x;
    logic [EXT_W-1:0]       size_y;
    logic [EXT_W-1:0]       size_z;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic                   hit;
    logic [HIT_INDEX_W-1:0] hit_index;
    logic [ID_W-1:0]        hit_id;
    logic                   both_ways;
    logic                   last;
  } result_t;

  typedef struct packed {
    logic [ID_W-1:0]         id;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [EXT_W-1:0]        radius;
    logic [EXT_W-1:0]        size_x;
    logic [EXT_W-1:0]        size_y;
    logic [EXT_W-1:0]        size_z;
  } entry_t;

  typedef struct packed {
    logic                   en;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
  } cfg_write_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic last_addr;
    logic pipe_busy;
  } dp_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

endpackage

// File: design/sbopd_ctrl.sv
// control state machine: scan sequencing, pipeline drain and closing word
module sbopd_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [sbopd_pkg::ACTION_W-1:0] action,
  input  sbopd_pkg::dp_status_t        stat,
  output sbopd_pkg::dp_cmd_t           cmd,
  output logic                         busy
);
  import sbopd_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          if ((action inside {ACT_APPEND, ACT_QUERY}) && !stat.count_zero) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_SCAN: begin
        if (stat.last_addr) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd.load   = 1'b0;
    cmd.issue  = 1'b0;
    cmd.finish = 1'b0;
    busy       = 1'b1;
    case (state)
      S_IDLE: begin
        cmd.load = start;
        busy     = 1'b0;
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
      end
      S_DRAIN: begin
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: design/sbopd_datapath.sv
// datapath: entry table, compare pipeline, config registers and result word
module sbopd_datapath #(
  parameter int TABLE_DEPTH = sbopd_pkg::DEF_TABLE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  sbopd_pkg::in_word_t   item,
  input  sbopd_pkg::cfg_write_t cfg_wr,
  input  sbopd_pkg::dp_cmd_t    cmd,
  output sbopd_pkg::dp_status_t stat,
  output sbopd_pkg::result_t    result,
  output logic                  result_valid
);
  import sbopd_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int SQ_W  = 2 * POS_W;
  localparam int SUM_W = SQ_W + 2;

  function automatic logic [POS_W-1:0] abs_diff(input logic signed [POS_W-1:0] a,
                                                input logic signed [POS_W-1:0] b);
    logic signed [POS_W:0] d;
    logic [POS_W:0]        m;
    d = {a[POS_W-1], a} - {b[POS_W-1], b};
    m = d[POS_W] ? (~d + 1'b1) : d;
    return m[POS_W-1:0];
  endfunction

  logic             shape_kind;
  logic             mode_mutual;
  in_word_t         q;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] addr;
  logic             dup;

  entry_t           mem [TABLE_DEPTH];
  entry_t           rd_entry;
  logic             rd_valid;
  logic [IDX_W-1:0] rd_idx;

  logic             a_valid;
  logic [IDX_W-1:0] a_idx;
  logic             a_idm;
  logic [ID_W-1:0]  a_id;
  logic [POS_W-1:0] a_dx, a_dy, a_dz;
  logic [POS_W-1:0] a_rs;
  logic [POS_W-1:0] a_bx, a_by, a_bz;

  logic             b_valid;
  logic [IDX_W-1:0] b_idx;
  logic             b_idm;
  logic [ID_W-1:0]  b_id;
  logic [SQ_W-1:0]  b_sqx, b_sqy, b_sqz;
  logic [SQ_W-1:0]  b_rs2;
  logic             b_box_ok;

  logic [SUM_W-1:0] d2;
  logic             overlap;
  logic             emit_hit;
  logic             full;
  logic             mem_we;
  entry_t           new_entry;
  result_t          hit_word;
  result_t          fin_word;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      shape_kind  <= 1'b0;
      mode_mutual <= 1'b0;
    end else if (cfg_wr.en) begin
      case (cfg_wr.index)
        CFG_SHAPE_KIND:  shape_kind  <= cfg_wr.data[0];
        CFG_MODE_MUTUAL: mode_mutual <= cfg_wr.data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q <= item;
    end
  end

  assign full   = (count == CNT_W'(TABLE_DEPTH));
  assign mem_we = cmd.finish && (q.action == ACT_APPEND) && !dup && !full;

  always_comb begin
    new_entry.id     = q.entry_id;
    new_entry.pos_x  = q.pos_x;
    new_entry.pos_y  = q.pos_y;
    new_entry.pos_z  = q.pos_z;
    new_entry.radius = q.radius;
    new_entry.size_x = q.size_x;
    new_entry.size_y = q.size_y;
    new_entry.size_z = q.size_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.finish) begin
      if (q.action == ACT_CLEAR) begin
        count <= '0;
      end else if (mem_we) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr <= '0;
    end else if (cmd.issue) begin
      addr <= addr + IDX_W'(1);
    end
  end

  // entry table
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count[IDX_W-1:0]] <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    rd_entry <= mem[addr];
    rd_idx   <= addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      a_valid  <= 1'b0;
      b_valid  <= 1'b0;
    end else begin
      rd_valid <= cmd.issue;
      a_valid  <= rd_valid;
      b_valid  <= a_valid;
    end
  end

  // distances and summed extents
  always_ff @(posedge clk) begin
    a_idx <= rd_idx;
    a_id  <= rd_entry.id;
    a_idm <= (rd_entry.id == q.entry_id);
    a_dx  <= abs_diff(q.pos_x, rd_entry.pos_x);
    a_dy  <= abs_diff(q.pos_y, rd_entry.pos_y);
    a_dz  <= abs_diff(q.pos_z, rd_entry.pos_z);
    a_rs  <= POS_W'(q.radius) + POS_W'(rd_entry.radius);
    a_bx  <= POS_W'(q.size_x) + POS_W'(rd_entry.size_x);
    a_by  <= POS_W'(q.size_y) + POS_W'(rd_entry.size_y);
    a_bz  <= POS_W'(q.size_z) + POS_W'(rd_entry.size_z);
  end

  // squares and box test
  always_ff @(posedge clk) begin
    b_idx    <= a_idx;
    b_id     <= a_id;
    b_idm    <= a_idm;
    b_sqx    <= SQ_W'(a_dx) * SQ_W'(a_dx);
    b_sqy    <= SQ_W'(a_dy) * SQ_W'(a_dy);
    b_sqz    <= SQ_W'(a_dz) * SQ_W'(a_dz);
    b_rs2    <= SQ_W'(a_rs) * SQ_W'(a_rs);
    b_box_ok <= ({a_dx, 1'b0} <= {1'b0, a_bx}) &&
                ({a_dy, 1'b0} <= {1'b0, a_by}) &&
                ({a_dz, 1'b0} <= {1'b0, a_bz});
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dup <= 1'b0;
    end else if (a_valid && a_idm) begin
      dup <= 1'b1;
    end
  end

  assign d2       = SUM_W'(b_sqx) + SUM_W'(b_sqy) + SUM_W'(b_sqz);
  assign overlap  = shape_kind ? b_box_ok : (d2 < SUM_W'(b_rs2));
  assign emit_hit = b_valid && (q.action == ACT_QUERY) && !b_idm && overlap;

  always_comb begin
    hit_word.status    = STAT_OK;
    hit_word.hit       = 1'b1;
    hit_word.hit_index = HIT_INDEX_W'(b_idx);
    hit_word.hit_id    = b_id;
    hit_word.both_ways = mode_mutual;
    hit_word.last      = 1'b0;

    fin_word.status    = STAT_OK;
    fin_word.hit       = 1'b0;
    fin_word.hit_index = '0;
    fin_word.hit_id    = '0;
    fin_word.both_ways = 1'b0;
    fin_word.last      = 1'b1;
    if (q.action == ACT_APPEND) begin
      if (dup) begin
        fin_word.status = STAT_DUP;
      end else if (full) begin
        fin_word.status = STAT_FULL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= emit_hit || cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result <= fin_word;
    end else if (emit_hit) begin
      result <= hit_word;
    end
  end

  assign stat.count_zero = (count == '0);
  assign stat.last_addr  = ((CNT_W'(addr) + CNT_W'(1)) == count);
  assign stat.pipe_busy  = rd_valid || a_valid || b_valid;

endmodule

// File: design/sphere_box_overlap_pair_detector_core.sv
// top level of the sphere and box overlap pair detector
// An item is taken when start is high and busy is low. Clear, an unused action
// code, and append or query on an empty table go from idle straight to the
// finishing state. Append and query on a table of N entries read the entry
// table once per entry, one entry a cycle, through a four-stage compare
// pipeline (table read, distances, squares, sum and compare), drain the pipeline
// and finish before the next item is taken. Each result word sits
// on result for exactly one cycle with result_valid high; the receiver must
// take it then. A query gives its hit words in slot order and then one closing
// word with last set; every other item gives one word with last set.
// Configuration writes are always taken (cfg_ready is tied high) and must be
// issued only while the block is idle; indexes outside the register list are
// ignored.
module sphere_box_overlap_pair_detector_core #(
  parameter int TABLE_DEPTH = sbopd_pkg::DEF_TABLE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  sbopd_pkg::in_word_t               item,
  output logic                              result_valid,
  output sbopd_pkg::result_t                result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sbopd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sbopd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sbopd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t stat;
  cfg_write_t cfg_wr;

  assign cfg_ready    = 1'b1;
  assign cfg_wr.en    = cfg_valid && cfg_ready;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  sbopd_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (item.action),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  sbopd_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg_wr       (cfg_wr),
    .cmd          (cmd),
    .stat         (stat),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule

// File: design/sbopd_checker.sv
// port-level checker for the overlap pair detector and its bind
module sbopd_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               result_valid,
  input sbopd_pkg::result_t result
);
  import sbopd_pkg::*;

  // an accepted item keeps the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // hit words never close an item, closing words never carry a hit
  a_hit_last: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.hit != result.last))
    else $error("hit and last not exclusive");

  a_nohit_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.hit) |->
      (result.hit_index == '0 && result.hit_id == '0 && result.both_ways == 1'b0))
    else $error("hit fields set on a non-hit word");

  // dropping busy comes with the closing word
  a_idle_closes: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> (result_valid && result.last))
    else $error("busy fell without a closing word");

endmodule

bind sphere_box_overlap_pair_detector_core sbopd_checker u_sbopd_checker (.*);

// File: tb/sv/tb.sv
// testbench of the overlap pair detector core: table walk, random sequences, predictor check
module tb;
  import sbopd_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam logic signed [POS_W-1:0] MAXP = 24'sh7FFFFF;
  localparam logic signed [POS_W-1:0] MINP = 24'sh800000;
  localparam logic [EXT_W-1:0] MAXE = 23'h7FFFFF;
  localparam result_t DONE_OK = '{STAT_OK, 1'b0, 5'd0, 16'd0, 1'b0, 1'b1};
  localparam result_t DONE_DUP = '{STAT_DUP, 1'b0, 5'd0, 16'd0, 1'b0, 1'b1};
  localparam result_t NO_RES = '0;
  localparam logic signed [POS_W-1:0] CORNER_POS [4] = '{MAXP, MINP, 24'sd0, -24'sd1};
  localparam int IN_W = $bits(in_word_t);

  typedef struct {
    bit       set_cfg;
    bit       shape;
    bit       mutual;
    in_word_t word;
    bit       typed;
    result_t  want;
  } dir_row_t;

  localparam int N_ROWS = 21;
  dir_row_t dir_rows [N_ROWS] = '{
    '{1'b0, 1'b0, 1'b0, '{ACT_QUERY, 16'd0, 24'sd0, 24'sd0, 24'sd0, 23'd0, 23'd0, 23'd0, 23'd0},
      1'b1, DONE_OK},
    '{1'b0, 1'b0, 1'b0, '{ACT_UNUSED, 16'hFFFF, MAXP, MAXP, MAXP, MAXE, MAXE, MAXE, MAXE},
      1'b1, DONE_OK},
    '{1'b0, 1'b0, 1'b0, '{ACT_CLEAR, 16'd0, 24'sd0, 24'sd0, 24'sd0, 23'd0, 23'd0, 23'd0, 23'd0},
      1'b1, DONE_OK},
    '{1'b0, 1'b0, 1'b0,
      '{ACT_APPEND, 16'd1, 24'sd0, 24'sd0, 24'sd0, 23'd256, 23'd512, 23'd512, 23'd512},
      1'b1, DONE_OK},
    '{1'b0, 1'b0, 1'b0, '{ACT_APPEND, 16'd1, 24'sd5, 24'sd5, 24'sd5, 23'd0, 23'd0, 23'd0, 23'd0},
      1'b1, DONE_DUP},
    '{1'b0, 1'b0, 1'b0,
      '{ACT_APPEND, 16'd2, 24'sd300, 24'sd0, 24'sd0, 23'd100, 23'd0, 23'd0, 23'd0},
      1'b1, DONE_OK},
    '{1'b0, 1'b0, 1'b0, '{ACT_APPEND, 16'd3, MAXP, MAXP, MAXP, MAXE, MAXE, MAXE, MAXE},
      1'b1, DONE_OK},
    '{1'b0, 1'b0, 1'b0, '{ACT_APPEND, 16'hFFFF, MINP, MINP, MINP, MAXE, MAXE, MAXE, MAXE},
      1'b1, DONE_OK},
    '{1'b0, 1'b0, 1'b0,
      '{ACT_QUERY, 16'd1, 24'sd0, 24'sd0, 24'sd0, 23'd256, 23'd512, 23'd512, 23'd512},
      1'b0, NO_RES},
    '{1'b0, 1'b0, 1'b0,
      '{ACT_QUERY, 16'd9, 24'sd512, 24'sd0, 24'sd0, 23'd256, 23'd0, 23'd0, 23'd0},
      1'b0, NO_RES},
    '{1'b0, 1'b0, 1'b0, '{ACT_QUERY, 16'd5, MAXP, MAXP, MAXP, MAXE, 23'd0, 23'd0, 23'd0},
      1'b0, NO_RES},
    '{1'b0, 1'b0, 1'b0, '{ACT_QUERY, 16'd0, MINP, MINP, MINP, 23'd0, 23'd0, 23'd0, 23'd0},
      1'b0, NO_RES},
    '{1'b1, 1'b1, 1'b1,
      '{ACT_QUERY, 16'd8, 24'sd512, 24'sd0, 24'sd0, 23'd0, 23'd512, 23'd512, 23'd512},
      1'b0, NO_RES},
    '{1'b0, 1'b0, 1'b0, '{ACT_QUERY, 16'd4, 24'sd0, 24'sd0, 24'sd0, 23'd0, 23'd0, 23'd0, 23'd0},
      1'b0, NO_RES},
    '{1'b0, 1'b0, 1'b0, '{ACT_QUERY, 16'd6, MINP, MINP, MINP, 23'd0, MAXE, MAXE, MAXE},
      1'b0, NO_RES},
    '{1'b0, 1'b0, 1'b0, '{ACT_QUERY, 16'hFFFF, MAXP, MAXP, MAXP, 23'd0, 23'd0, 23'd0, 23'd0},
      1'b0, NO_RES},
    '{1'b1, 1'b0, 1'b1,
      '{ACT_QUERY, 16'd2, 24'sd300, 24'sd0, 24'sd0, 23'd100, 23'd0, 23'd0, 23'd0},
      1'b0, NO_RES},
    '{1'b0, 1'b0, 1'b0, '{ACT_CLEAR, 16'd7, 24'sd0, 24'sd0, 24'sd0, 23'd0, 23'd0, 23'd0, 23'd0},
      1'b1, DONE_OK},
    '{1'b0, 1'b0, 1'b0, '{ACT_QUERY, 16'd1, 24'sd0, 24'sd0, 24'sd0, 23'd0, 23'd0, 23'd0, 23'd0},
      1'b1, DONE_OK},
    '{1'b0, 1'b0, 1'b0,
      '{ACT_APPEND, 16'd1, -24'sd1, -24'sd1, -24'sd1, 23'd0, 23'd0, 23'd0, 23'd0},
      1'b1, DONE_OK},
    '{1'b0, 1'b0, 1'b0,
      '{ACT_QUERY, 16'd2, -24'sd1, -24'sd1, -24'sd1, 23'd1, 23'd0, 23'd0, 23'd0},
      1'b0, NO_RES}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  in_word_t item = '0;
  logic result_valid;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_SHAPE_KIND;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  sphere_box_overlap_pair_detector_core uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .result_valid(result_valid),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the collider table and registers
  entry_t stored [DEF_TABLE_DEPTH];
  int stored_count = 0;
  bit shape_box = 1'b0;
  bit mutual_on = 1'b0;

  result_t pending_results [$];
  int mismatches = 0;
  int words_in = 0;
  int counted_words = 0;
  int words_checked = 0;
  int hits_seen = 0;
  int full_seen = 0;
  int dup_seen = 0;
  int idle_pct = 0;

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s at %0t: got %0d want %0d", what, $time, got, want);
    mismatches++;
  endtask

  function automatic bit overlap_found(entry_t e, in_word_t w);
    longint dx, dy, dz, rs;
    dx = longint'($signed(w.pos_x)) - longint'($signed(e.pos_x));
    dy = longint'($signed(w.pos_y)) - longint'($signed(e.pos_y));
    dz = longint'($signed(w.pos_z)) - longint'($signed(e.pos_z));
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    if (dz < 0) dz = -dz;
    if (shape_box) begin
      return 2 * dx <= longint'(w.size_x) + longint'(e.size_x) &&
             2 * dy <= longint'(w.size_y) + longint'(e.size_y) &&
             2 * dz <= longint'(w.size_z) + longint'(e.size_z);
    end
    rs = longint'(w.radius) + longint'(e.radius);
    return dx * dx + dy * dy + dz * dz < rs * rs;
  endfunction

  task automatic predict_word(in_word_t w, bit keep);
    result_t out [$];
    result_t r;
    bit dup;
    r = DONE_OK;
    dup = 1'b0;
    case (w.action)
      ACT_CLEAR: stored_count = 0;
      ACT_APPEND: begin
        for (int s = 0; s < stored_count; s++)
          if (stored[s].id == w.entry_id) dup = 1'b1;
        if (dup) begin
          r.status = STAT_DUP;
        end else if (stored_count >= DEF_TABLE_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          stored[stored_count] = '{w.entry_id, w.pos_x, w.pos_y, w.pos_z, w.radius,
                                   w.size_x, w.size_y, w.size_z};
          stored_count++;
        end
      end
      ACT_QUERY: begin
        for (int s = 0; s < stored_count; s++) begin
          if (stored[s].id != w.entry_id && overlap_found(stored[s], w))
            out.push_back('{STAT_OK, 1'b1, HIT_INDEX_W'(s), stored[s].id, mutual_on, 1'b0});
        end
      end
      default: ;
    endcase
    out.push_back(r);
    if (keep) foreach (out[i]) pending_results.push_back(out[i]);
  endtask

  task automatic push_word(in_word_t w, bit typed, result_t want);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while (busy || $urandom_range(99) < idle_pct);
    end
    start <= 1'b1;
    item <= w;
    do @(posedge clk); while (busy);
    words_in++;
    if (w.action != ACT_UNUSED) counted_words++;
    predict_word(w, !typed);
    if (typed) pending_results.push_back(want);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic set_mode(bit shape, bit mutual);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_SHAPE_KIND;
    cfg_data <= shape;
    do @(posedge clk); while (!cfg_ready);
    shape_box = shape;
    cfg_index <= CFG_MODE_MUTUAL;
    cfg_data <= mutual;
    do @(posedge clk); while (!cfg_ready);
    mutual_on = mutual;
    cfg_valid <= 1'b0;
  endtask

  function automatic in_word_t make_word(logic [ACTION_W-1:0] act);
    in_word_t w;
    int spread;
    spread = $urandom_range(0, 9);
    w = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    w.action = act;
    if (spread < 7) begin
      // clustered around the origin so overlaps are common
      w.entry_id = ID_W'($urandom_range(0, 39));
      w.pos_x = POS_W'(int'($urandom_range(0, 8191)) - 4096);
      w.pos_y = POS_W'(int'($urandom_range(0, 8191)) - 4096);
      w.pos_z = POS_W'(int'($urandom_range(0, 8191)) - 4096);
      w.radius = EXT_W'($urandom_range(0, 3000));
      w.size_x = EXT_W'($urandom_range(0, 6000));
      w.size_y = EXT_W'($urandom_range(0, 6000));
      w.size_z = EXT_W'($urandom_range(0, 6000));
    end else if (spread == 9) begin
      w.entry_id = $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
      w.pos_x = CORNER_POS[2'($urandom_range(0, 3))];
      w.pos_y = CORNER_POS[2'($urandom_range(0, 3))];
      w.pos_z = CORNER_POS[2'($urandom_range(0, 3))];
      w.radius = $urandom_range(0, 1) ? MAXE : '0;
      w.size_x = $urandom_range(0, 1) ? MAXE : '0;
      w.size_y = $urandom_range(0, 1) ? MAXE : '0;
      w.size_z = $urandom_range(0, 1) ? MAXE : '0;
    end
    return w;
  endfunction

  task automatic run_phase(bit shape, bit mutual, int pct, int goal, bit fill_first);
    in_word_t w;
    int n_app;
    int kind;
    wait_idle();
    set_mode(shape, mutual);
    goal = counted_words + goal;
    while (counted_words < goal) begin
      idle_pct = ($urandom_range(9) == 0) ? 0 : pct;
      kind = $urandom_range(0, 9);
      if (fill_first) begin
        // fill past the table depth so the full refusal shows up
        push_word(make_word(ACT_CLEAR), 1'b0, NO_RES);
        for (int i = 0; i < DEF_TABLE_DEPTH + 3; i++) begin
          w = make_word(ACT_APPEND);
          w.entry_id = ID_W'(1000 + i);
          push_word(w, 1'b0, NO_RES);
        end
        for (int i = 0; i < 4; i++) push_word(make_word(ACT_QUERY), 1'b0, NO_RES);
        fill_first = 1'b0;
      end else if (kind < 7) begin
        if ($urandom_range(0, 2) == 0) push_word(make_word(ACT_CLEAR), 1'b0, NO_RES);
        n_app = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 36) : $urandom_range(1, 12);
        for (int i = 0; i < n_app; i++) push_word(make_word(ACT_APPEND), 1'b0, NO_RES);
        for (int i = $urandom_range(1, 4); i > 0; i--)
          push_word(make_word(ACT_QUERY), 1'b0, NO_RES);
      end else begin
        push_word(make_word(ACTION_W'($urandom_range(0, 3))), 1'b0, NO_RES);
      end
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("word with nothing pending", 1, 0);
      end else begin
        want = pending_results.pop_front();
        words_checked++;
        if (want.hit) hits_seen++;
        if (want.status == STAT_FULL) full_seen++;
        if (want.status == STAT_DUP) dup_seen++;
        if (result.status !== want.status)
          report_mismatch("status", int'(result.status), int'(want.status));
        if (result.hit !== want.hit)
          report_mismatch("hit", int'(result.hit), int'(want.hit));
        if (result.hit_index !== want.hit_index)
          report_mismatch("hit_index", int'(result.hit_index), int'(want.hit_index));
        if (result.hit_id !== want.hit_id)
          report_mismatch("hit_id", int'(result.hit_id), int'(want.hit_id));
        if (result.both_ways !== want.both_ways)
          report_mismatch("both_ways", int'(result.both_ways), int'(want.both_ways));
        if (result.last !== want.last)
          report_mismatch("last", int'(result.last), int'(want.last));
      end
    end
  end

  initial begin
    int waited;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_cfg) begin
        wait_idle();
        set_mode(dir_rows[i].shape, dir_rows[i].mutual);
      end
      push_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);
    end
    run_phase(1'b0, 1'b0, 0, 65, 1'b1);
    run_phase(1'b1, 1'b1, 88, 65, 1'b0);
    run_phase(1'b0, 1'b1, 22, 65, 1'b0);
    run_phase(1'b1, 1'b0, 0, 65, 1'b1);
    start <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DEF_TABLE_DEPTH + 10) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("words never seen", 0, pending_results.size());
    $display("covered %0d words in, %0d result words checked, %0d of them hits",
             words_in, words_checked, hits_seen);
    $display("%0d full and %0d duplicate refusals, sphere and box tests, mutual on and off",
             full_seen, dup_seen);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("tb failed");
    $finish;
  end

endmodule

// File: sim.f
design/sbopd_pkg.sv
design/sbopd_ctrl.sv
design/sbopd_datapath.sv
design/sphere_box_overlap_pair_detector_core.sv
design/sbopd_checker.sv
tb/sv/tb.sv
